/* rtl/core/dcmb_pkg.sv */
// Shared types, constants and helpers for the diversity combiner.
// Used by dcmb_div, dcmb_prep and diversity_combiner_mrc_egc_sc; no dependencies.
package dcmb_pkg;

  localparam int NANT   = 4;                  // antenna branches
  localparam int AW     = $clog2(NANT);       // antenna index width
  localparam int LW     = $clog2(NANT + 1);   // antenna count width
  localparam int SBITS  = 16;                 // sample width
  localparam int CWID   = 32;                 // channel estimate register width
  localparam int HBITS  = CWID / 2;           // one part of a channel estimate
  localparam int CIW    = $clog2(NANT + 2);   // register index width

  // channel power and magnitude
  localparam int PW_W     = 2 * HBITS;
  localparam int PSUM_W   = PW_W + $clog2(NANT);
  localparam int ROOT_PRE = 16;               // power scaled by 2^16 before the root
  localparam int ROOT_W   = PW_W + ROOT_PRE;
  localparam int ROOT_IT  = ROOT_W / 2;
  localparam int KW       = $clog2(ROOT_IT);
  localparam int MAG_W    = ROOT_IT;
  localparam int MAG_MIN  = 256;              // one LSB of Q1.15 in magnitude units

  // products and sums
  localparam int PROD_W = HBITS + SBITS;
  localparam int CPX_W  = PROD_W + 1;
  localparam int NSUM_W = CPX_W + $clog2(NANT);

  // pipelined divider
  localparam int DV_NW  = 50;
  localparam int DV_DW  = 35;
  localparam int DV_QB  = 25;
  localparam int DV_CW  = DV_DW + DV_QB;
  localparam int DV_LAT = DV_QB + 1;
  localparam int MRC_SH = 16;                 // 2^15 scale plus rounding doubling
  localparam int EGC_SH = 17;                 // 2^16 scale plus rounding doubling
  localparam int EGC_FRAC = 8;                // extra fraction bits of an EGC term
  localparam int VW     = DV_QB + 1 + $clog2(NANT) + 1;
  localparam int DF_W   = $clog2(NANT * (1 << EGC_FRAC) + 1);

  // pipeline positions
  localparam int POS_DIV1 = 4;
  localparam int POS_CMB  = POS_DIV1 + DV_LAT;
  localparam int LAT      = POS_CMB + 1 + DV_LAT + 1;

  typedef enum logic [1:0] {
    MODE_MRC = 2'd0,
    MODE_EGC = 2'd1,
    MODE_SEL = 2'd2,
    MODE_BAD = 2'd3
  } dcmb_mode_t;

  localparam logic [CIW-1:0] REG_MODE      = CIW'(0);
  localparam logic [CIW-1:0] REG_ANTS      = CIW'(1);
  localparam logic [CIW-1:0] REG_CHAN0     = CIW'(2);
  localparam logic [CIW-1:0] REG_CHAN_LAST = CIW'(2 + NANT - 1);

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_POW,
    PS_ROOT,
    PS_SUM
  } dcmb_pstate_t;

  typedef struct packed {
    logic                        busy;
    logic [AW-1:0]               best;
    logic [PSUM_W-1:0]           psum;
    logic [NANT-1:0][MAG_W-1:0]  mag;
  } dcmb_prep_t;

  typedef struct packed {
    logic signed [SBITS-1:0] rx0_re;
    logic signed [SBITS-1:0] rx0_im;
    logic signed [SBITS-1:0] rx1_re;
    logic signed [SBITS-1:0] rx1_im;
    logic signed [SBITS-1:0] rx2_re;
    logic signed [SBITS-1:0] rx2_im;
    logic signed [SBITS-1:0] rx3_re;
    logic signed [SBITS-1:0] rx3_im;
  } dcmb_in_t;

  typedef struct packed {
    logic signed [SBITS-1:0] out_re;
    logic signed [SBITS-1:0] out_im;
    logic                    saturated;
    logic                    bad_mode;
  } dcmb_out_t;

  // zero counts as one branch, too many as all of them
  function automatic logic [LW-1:0] ants_clamp(input logic [2:0] a);
    logic [LW-1:0] r;
    if (a == 3'd0) begin
      r = LW'(1);
    end else if (32'(a) > NANT) begin
      r = LW'(NANT);
    end else begin
      r = LW'(a);
    end
    return r;
  endfunction

endpackage

/* rtl/core/dcmb_div.sv */
// Pipelined restoring divider: one quotient bit per stage, overflow flag.
// Depends on dcmb_pkg for widths; the caller tracks valid bits.
module dcmb_div import dcmb_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DV_NW-1:0] num,
  input  logic [DV_DW-1:0] den,
  input  logic             neg,
  output logic [DV_QB-1:0] quo,
  output logic             ovf,
  output logic             neg_o
);

  logic [DV_NW-1:0] rem_r [DV_QB+1];
  logic [DV_DW-1:0] den_r [DV_QB+1];
  logic [DV_QB-1:0] quo_r [DV_QB+1];
  logic             neg_r [DV_QB+1];
  logic             ovf_r [DV_QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= 1'b0;
    end
  end

  for (genvar s = 0; s < DV_QB; s++) begin : g_stage
    localparam int K = DV_QB - 1 - s;
    logic [DV_CW-1:0] trial;
    logic             ge;
    logic             big;

    assign trial = DV_CW'(den_r[s]) << K;
    assign ge    = DV_CW'(rem_r[s]) >= trial;
    // quotient cannot hold the result: checked once, at the top bit
    assign big   = (s == 0) && (DV_CW'(rem_r[s]) >= (DV_CW'(den_r[s]) << DV_QB));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? (rem_r[s] - trial[DV_NW-1:0]) : rem_r[s];
        quo_r[s+1] <= {quo_r[s][DV_QB-2:0], ge};
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s] | big;
      end
    end
  end

  assign quo   = quo_r[DV_QB];
  assign ovf   = ovf_r[DV_QB];
  assign neg_o = neg_r[DV_QB];

endmodule

/* rtl/core/dcmb_prep.sv */
// Channel preparation: per-antenna power and magnitude, power sum, strongest branch.
// Depends on dcmb_pkg; runs one square-root step per cycle after a channel or count write.
module dcmb_prep import dcmb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NANT-1:0][CWID-1:0]  chan,
  input  logic [LW-1:0]              ants,
  output dcmb_prep_t                 prep_o
);

  dcmb_pstate_t               st_r, st_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [KW-1:0]              k_r, k_nxt;
  logic [ROOT_W-1:0]          rad_r, rad_nxt;
  logic [ROOT_W-1:0]          res_r, res_nxt;
  logic [NANT-1:0][PW_W-1:0]  pw_r, pw_nxt;
  logic [NANT-1:0][MAG_W-1:0] mag_r, mag_nxt;
  logic [PSUM_W-1:0]          psum_r, psum_nxt;
  logic [AW-1:0]              best_r, best_nxt;

  logic signed [HBITS-1:0]    hr, hi;
  logic signed [PW_W-1:0]     sq_r, sq_i;
  logic [PW_W-1:0]            pw_new;
  logic [ROOT_W-1:0]          bitv, trial, res_step;
  logic                       ge;
  logic [PSUM_W-1:0]          sum_val;
  logic [AW-1:0]              best_val;

  assign hr     = signed'(chan[idx_r][CWID-1:HBITS]);
  assign hi     = signed'(chan[idx_r][HBITS-1:0]);
  assign sq_r   = hr * hr;
  assign sq_i   = hi * hi;
  assign pw_new = $unsigned(sq_r) + $unsigned(sq_i);

  assign bitv     = ROOT_W'(1) << {k_r, 1'b0};
  assign trial    = res_r + bitv;
  assign ge       = rad_r >= trial;
  assign res_step = ge ? ((res_r >> 1) + bitv) : (res_r >> 1);

  always_comb begin
    sum_val  = '0;
    best_val = '0;
    for (int l = 0; l < NANT; l++) begin
      if (LW'(l) < ants) begin
        sum_val = sum_val + PSUM_W'(pw_r[l]);
        if (pw_r[l] > pw_r[best_val]) begin
          best_val = AW'(l);
        end
      end
    end
    // floor the power to one LSB
    if (sum_val == '0) begin
      sum_val = PSUM_W'(1);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    k_nxt    = k_r;
    rad_nxt  = rad_r;
    res_nxt  = res_r;
    pw_nxt   = pw_r;
    mag_nxt  = mag_r;
    psum_nxt = psum_r;
    best_nxt = best_r;
    unique case (st_r)
      PS_IDLE: begin
      end
      PS_POW: begin
        pw_nxt[idx_r] = pw_new;
        rad_nxt       = ROOT_W'(pw_new) << ROOT_PRE;
        res_nxt       = '0;
        k_nxt         = KW'(ROOT_IT - 1);
        st_nxt        = PS_ROOT;
      end
      PS_ROOT: begin
        res_nxt = res_step;
        if (ge) begin
          rad_nxt = rad_r - trial;
        end
        if (k_r == '0) begin
          mag_nxt[idx_r] = (res_step < ROOT_W'(MAG_MIN)) ? MAG_W'(MAG_MIN)
                                                         : res_step[MAG_W-1:0];
          if (idx_r == AW'(NANT - 1)) begin
            st_nxt = PS_SUM;
          end else begin
            idx_nxt = idx_r + AW'(1);
            st_nxt  = PS_POW;
          end
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      PS_SUM: begin
        psum_nxt = sum_val;
        best_nxt = best_val;
        st_nxt   = PS_IDLE;
      end
    endcase
    // restart on any new channel or count write
    if (start) begin
      st_nxt  = PS_POW;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= PS_IDLE;
      idx_r  <= '0;
      mag_r  <= {NANT{MAG_W'(MAG_MIN)}};
      psum_r <= PSUM_W'(1);
      best_r <= '0;
      pw_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      mag_r  <= mag_nxt;
      psum_r <= psum_nxt;
      best_r <= best_nxt;
      pw_r   <= pw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    rad_r <= rad_nxt;
    res_r <= res_nxt;
  end

  assign prep_o.busy = (st_r != PS_IDLE);
  assign prep_o.best = best_r;
  assign prep_o.psum = psum_r;
  assign prep_o.mag  = mag_r;

endmodule

/* rtl/core/diversity_combiner_mrc_egc_sc.sv */
// Diversity combiner top level: MRC, EGC and selection over up to four branches.
// Depends on dcmb_pkg, dcmb_div and dcmb_prep.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | dcmb_in_t, one sample per antenna
//   out_    | output    | out_valid/out_stall | dcmb_out_t, combined sample and flags
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (one register)
//
// One word enters per cycle while in_stall is low; the data runs through two 26-stage divider pipes.
// A write to antennas_in_use or a channel register holds in_stall while the prep
// unit runs four 24-step square roots, one step per cycle.
// cfg_ready stays low while any word is in flight; a pending write holds in_stall.
// Reset needs no clearing pass; the reset magnitudes and power sum are loaded directly.
// out_stall while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
module diversity_combiner_mrc_egc_sc import dcmb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dcmb_in_t        in_word,
  output logic            out_valid,
  input  logic            out_stall,
  output dcmb_out_t       out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CIW-1:0]  cfg_index,
  input  logic [CWID-1:0] cfg_data
);

  localparam logic [DV_QB-1:0] SMAX = DV_QB'((1 << (SBITS - 1)) - 1);
  localparam logic [DV_QB-1:0] NLIM = DV_QB'(1 << (SBITS - 1));

  dcmb_mode_t                mode_r;
  logic [2:0]                ants_r;
  logic [NANT-1:0][CWID-1:0] chan_r;
  logic [LW-1:0]             lcnt;
  logic                      cfg_wr, prep_start;
  dcmb_prep_t                prep;

  logic            en, acc;
  logic [LAT-1:0]  vpipe_r;

  // ---------------- configuration ----------------
  // take a write only once the pipe is empty
  assign cfg_ready  = ~|vpipe_r;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign prep_start = cfg_wr && ((cfg_index == REG_ANTS) ||
                      ((cfg_index >= REG_CHAN0) && (cfg_index <= REG_CHAN_LAST)));
  assign lcnt       = ants_clamp(ants_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MRC;
      ants_r <= 3'd1;
      chan_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= dcmb_mode_t'(cfg_data[1:0]);
      end else if (cfg_index == REG_ANTS) begin
        ants_r <= cfg_data[2:0];
      end else if ((cfg_index >= REG_CHAN0) && (cfg_index <= REG_CHAN_LAST)) begin
        chan_r[AW'(cfg_index - REG_CHAN0)] <= cfg_data;
      end
    end
  end

  dcmb_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (prep_start),
    .chan   (chan_r),
    .ants   (lcnt),
    .prep_o (prep)
  );

  // ---------------- handshake ----------------
  assign out_valid = vpipe_r[LAT-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en || prep.busy || cfg_valid;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else if (en) begin
      vpipe_r <= {vpipe_r[LAT-2:0], acc};
    end
  end

  // ---------------- stage 1: capture ----------------
  dcmb_in_t s1_r;
  logic signed [SBITS-1:0] rx_re [NANT];
  logic signed [SBITS-1:0] rx_im [NANT];
  logic signed [HBITS-1:0] hr [NANT];
  logic signed [HBITS-1:0] hi [NANT];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_word;
    end
  end

  assign rx_re[0] = s1_r.rx0_re;
  assign rx_im[0] = s1_r.rx0_im;
  assign rx_re[1] = s1_r.rx1_re;
  assign rx_im[1] = s1_r.rx1_im;
  assign rx_re[2] = s1_r.rx2_re;
  assign rx_im[2] = s1_r.rx2_im;
  assign rx_re[3] = s1_r.rx3_re;
  assign rx_im[3] = s1_r.rx3_im;

  for (genvar l = 0; l < NANT; l++) begin : g_ch
    assign hr[l] = signed'(chan_r[l][CWID-1:HBITS]);
    assign hi[l] = signed'(chan_r[l][HBITS-1:0]);
  end

  // ---------------- stage 2: products ----------------
  logic signed [PROD_W-1:0] prr_r [NANT];
  logic signed [PROD_W-1:0] pii_r [NANT];
  logic signed [PROD_W-1:0] pri_r [NANT];
  logic signed [PROD_W-1:0] pir_r [NANT];
  logic signed [SBITS-1:0]  sel2_re_r, sel2_im_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NANT; l++) begin
        prr_r[l] <= hr[l] * rx_re[l];
        pii_r[l] <= hi[l] * rx_im[l];
        pri_r[l] <= hr[l] * rx_im[l];
        pir_r[l] <= hi[l] * rx_re[l];
      end
      sel2_re_r <= rx_re[prep.best];
      sel2_im_r <= rx_im[prep.best];
    end
  end

  // ---------------- stage 3: conj(h)*r per branch ----------------
  logic signed [CPX_W-1:0] cre_r [NANT];
  logic signed [CPX_W-1:0] cim_r [NANT];
  logic signed [SBITS-1:0] sel3_re_r, sel3_im_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NANT; l++) begin
        cre_r[l] <= CPX_W'(prr_r[l]) + CPX_W'(pii_r[l]);
        cim_r[l] <= CPX_W'(pri_r[l]) - CPX_W'(pir_r[l]);
      end
      sel3_re_r <= sel2_re_r;
      sel3_im_r <= sel2_im_r;
    end
  end

  // ---------------- stage 4: MRC numerator ----------------
  logic signed [CPX_W-1:0]  cre4_r [NANT];
  logic signed [CPX_W-1:0]  cim4_r [NANT];
  logic signed [NSUM_W-1:0] nre4_r, nim4_r;
  logic signed [NSUM_W-1:0] nre_sum, nim_sum;
  logic signed [SBITS-1:0]  sel4_re_r, sel4_im_r;

  always_comb begin
    nre_sum = '0;
    nim_sum = '0;
    for (int l = 0; l < NANT; l++) begin
      if (LW'(l) < lcnt) begin
        nre_sum = nre_sum + NSUM_W'(cre_r[l]);
        nim_sum = nim_sum + NSUM_W'(cim_r[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cre4_r    <= cre_r;
      cim4_r    <= cim_r;
      nre4_r    <= nre_sum;
      nim4_r    <= nim_sum;
      sel4_re_r <= sel3_re_r;
      sel4_im_r <= sel3_im_r;
    end
  end

  // ---------------- branch dividers ----------------
  // slot 2*l is the real part of branch l, 2*l+1 the imaginary part;
  // branch 0 also carries the MRC quotient and the selected sample
  logic [DV_NW-1:0] dv_num [2*NANT];
  logic [DV_DW-1:0] dv_den [2*NANT];
  logic             dv_neg [2*NANT];
  logic [DV_QB-1:0] dq     [2*NANT];
  logic             dovf   [2*NANT];
  logic             dneg   [2*NANT];

  always_comb begin
    logic signed [CPX_W-1:0]  c;
    logic [CPX_W-1:0]         cmag;
    logic signed [NSUM_W-1:0] n;
    logic [NSUM_W-1:0]        nmag;
    logic signed [SBITS-1:0]  sv;
    logic [SBITS-1:0]         smag;
    for (int l = 0; l < NANT; l++) begin
      for (int p = 0; p < 2; p++) begin
        c    = (p == 1) ? cim4_r[l] : cre4_r[l];
        cmag = c[CPX_W-1] ? CPX_W'(-c) : CPX_W'(c);
        dv_num[2*l+p] = (DV_NW'(cmag) << EGC_SH) + DV_NW'(prep.mag[l]);
        dv_den[2*l+p] = DV_DW'(prep.mag[l]) << 1;
        dv_neg[2*l+p] = c[CPX_W-1];
      end
    end
    for (int p = 0; p < 2; p++) begin
      n    = (p == 1) ? nim4_r : nre4_r;
      nmag = n[NSUM_W-1] ? NSUM_W'(-n) : NSUM_W'(n);
      sv   = (p == 1) ? sel4_im_r : sel4_re_r;
      smag = sv[SBITS-1] ? SBITS'(-sv) : SBITS'(sv);
      unique case (mode_r)
        MODE_MRC: begin
          dv_num[p] = (DV_NW'(nmag) << MRC_SH) + DV_NW'(prep.psum);
          dv_den[p] = DV_DW'(prep.psum) << 1;
          dv_neg[p] = n[NSUM_W-1];
        end
        MODE_SEL: begin
          // divide by one: pass the sample through the same pipe
          dv_num[p] = (DV_NW'(smag) << 1) + DV_NW'(1);
          dv_den[p] = DV_DW'(2);
          dv_neg[p] = sv[SBITS-1];
        end
        MODE_EGC, MODE_BAD: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < 2 * NANT; i++) begin : g_div
    dcmb_div u_div (
      .clk   (clk),
      .en    (en),
      .num   (dv_num[i]),
      .den   (dv_den[i]),
      .neg   (dv_neg[i]),
      .quo   (dq[i]),
      .ovf   (dovf[i]),
      .neg_o (dneg[i])
    );
  end

  // ---------------- combine stage ----------------
  logic signed [VW-1:0] v_r [2];
  logic signed [VW-1:0] v_nxt [2];

  always_comb begin
    logic signed [VW-1:0] acc_v;
    logic signed [VW-1:0] mag_v;
    for (int p = 0; p < 2; p++) begin
      acc_v = '0;
      for (int l = 0; l < NANT; l++) begin
        if (LW'(l) < lcnt) begin
          mag_v = $signed(VW'(dq[2*l+p]));
          acc_v = dneg[2*l+p] ? (acc_v - mag_v) : (acc_v + mag_v);
        end
      end
      // clip an overflowed quotient to a value that still saturates
      mag_v = dovf[p] ? $signed(VW'(1 << DV_QB)) : $signed(VW'(dq[p]));
      if (mode_r == MODE_EGC) begin
        v_nxt[p] = acc_v;
      end else begin
        v_nxt[p] = dneg[p] ? -mag_v : mag_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  // ---------------- final dividers ----------------
  logic [DV_NW-1:0] fv_num [2];
  logic [DV_DW-1:0] fv_den [2];
  logic             fv_neg [2];
  logic [DV_QB-1:0] fq     [2];
  logic             fovf   [2];
  logic             fneg   [2];
  logic [DF_W-1:0]  df;

  assign df = (mode_r == MODE_EGC) ? (DF_W'(lcnt) << EGC_FRAC) : DF_W'(1);

  always_comb begin
    logic [VW-1:0] vabs;
    for (int p = 0; p < 2; p++) begin
      vabs      = v_r[p][VW-1] ? VW'(-v_r[p]) : VW'(v_r[p]);
      fv_num[p] = (DV_NW'(vabs) << 1) + DV_NW'(df);
      fv_den[p] = DV_DW'(df) << 1;
      fv_neg[p] = v_r[p][VW-1];
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_fdiv
    dcmb_div u_fdiv (
      .clk   (clk),
      .en    (en),
      .num   (fv_num[p]),
      .den   (fv_den[p]),
      .neg   (fv_neg[p]),
      .quo   (fq[p]),
      .ovf   (fovf[p]),
      .neg_o (fneg[p])
    );
  end

  // ---------------- output register ----------------
  dcmb_out_t out_r, out_nxt;

  always_comb begin
    logic [SBITS-1:0] o [2];
    logic             sf [2];
    logic [DV_QB-1:0] qn;
    for (int p = 0; p < 2; p++) begin
      qn = -fq[p];
      if (fneg[p]) begin
        sf[p] = fovf[p] || (fq[p] > NLIM);
        o[p]  = sf[p] ? NLIM[SBITS-1:0] : qn[SBITS-1:0];
      end else begin
        sf[p] = fovf[p] || (fq[p] > SMAX);
        o[p]  = sf[p] ? SMAX[SBITS-1:0] : fq[p][SBITS-1:0];
      end
    end
    if (mode_r == MODE_BAD) begin
      out_nxt.out_re    = '0;
      out_nxt.out_im    = '0;
      out_nxt.saturated = 1'b0;
      out_nxt.bad_mode  = 1'b1;
    end else begin
      out_nxt.out_re    = signed'(o[0]);
      out_nxt.out_im    = signed'(o[1]);
      out_nxt.saturated = sf[0] | sf[1];
      out_nxt.bad_mode  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_word = out_r;

  // ---------------- assertions ----------------
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    prep.busy |-> in_stall)
    else $error("word accepted while channel prep is running");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    prep_start |=> prep.busy)
    else $error("channel prep did not start after a write");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vpipe_r))
    else $error("pipeline moved while output stalled");

  a_sel_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (mode_r == MODE_SEL)) |-> !out_word.saturated)
    else $error("selection result flagged as saturated");

endmodule

/* test/diversity_combiner_mrc_egc_sc_test.sv */
// Self-checking bench for diversity_combiner_mrc_egc_sc: directed vectors, then random
// words over many register settings, checked against a behavioral combiner model or typed results.
// Depends on dcmb_pkg and the RTL under rtl/core.
module diversity_combiner_mrc_egc_sc_test;
  import dcmb_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 370;

  typedef struct {
    dcmb_mode_t        mode;
    logic [2:0]        ants;
    logic [31:0]       ch[NANT];
    dcmb_in_t          word;
    bit                typed;
    dcmb_out_t         res;
  } vec_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  dcmb_in_t        in_word = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  dcmb_out_t       out_word;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CIW-1:0]  cfg_index = '0;
  logic [CWID-1:0] cfg_data = '0;

  // register mirror
  logic [1:0]  cur_mode = MODE_MRC;
  logic [2:0]  cur_ants = 3'd1;
  logic [31:0] cur_chan[NANT] = '{default: 32'h0};

  dcmb_out_t   combined_q[$];
  int          errors = 0;
  int          words_sent = 0;
  int          send_pct = 0;
  int          stall_pct = 0;
  int          quiet = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  vec_row_t    vec_rows[$];

  diversity_combiner_mrc_egc_sc uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // round(num * 2^sh / d), ties away from zero
  function automatic longint rnd_div(longint num, int sh, longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    mag = mag << sh;
    q = (2 * mag + d) / (2 * d);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clip16(longint v, ref bit f);
    if (v > 32767) begin
      f = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      f = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic dcmb_out_t combine(dcmb_in_t w);
    longint hr[NANT], hi[NANT], rr[NANT], ri[NANT];
    longint unsigned pw[NANT];
    longint unsigned p, m;
    longint nre, nim;
    int n, best;
    bit f;
    dcmb_out_t r;
    r = '0;
    f = 1'b0;
    n = (cur_ants == 0) ? 1 : (cur_ants > NANT) ? NANT : int'(cur_ants);
    rr = '{longint'(w.rx0_re), longint'(w.rx1_re), longint'(w.rx2_re), longint'(w.rx3_re)};
    ri = '{longint'(w.rx0_im), longint'(w.rx1_im), longint'(w.rx2_im), longint'(w.rx3_im)};
    for (int k = 0; k < NANT; k++) begin
      hr[k] = longint'($signed(cur_chan[k][31:16]));
      hi[k] = longint'($signed(cur_chan[k][15:0]));
      pw[k] = hr[k] * hr[k] + hi[k] * hi[k];
    end
    nre = 0;
    nim = 0;
    case (cur_mode)
      MODE_MRC: begin
        p = 0;
        for (int k = 0; k < n; k++) begin
          nre += hr[k] * rr[k] + hi[k] * ri[k];
          nim += hr[k] * ri[k] - hi[k] * rr[k];
          p += pw[k];
        end
        if (p < 1) p = 1;
        r.out_re = clip16(rnd_div(nre, 15, p), f);
        r.out_im = clip16(rnd_div(nim, 15, p), f);
      end
      MODE_EGC: begin
        for (int k = 0; k < n; k++) begin
          m = int_sqrt(pw[k] << 16);
          if (m < MAG_MIN) m = MAG_MIN;
          nre += rnd_div(hr[k] * rr[k] + hi[k] * ri[k], 16, m);
          nim += rnd_div(hr[k] * ri[k] - hi[k] * rr[k], 16, m);
        end
        r.out_re = clip16(rnd_div(nre, 0, longint'(n) << EGC_FRAC), f);
        r.out_im = clip16(rnd_div(nim, 0, longint'(n) << EGC_FRAC), f);
      end
      MODE_SEL: begin
        best = 0;
        for (int k = 1; k < n; k++)
          if (pw[k] > pw[best]) best = k;
        r.out_re = rr[best][15:0];
        r.out_im = ri[best][15:0];
      end
      default: r.bad_mode = 1'b1;
    endcase
    r.saturated = f;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(dcmb_in_t w, bit typed = 1'b0, dcmb_out_t res = '0);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    combined_q.push_back(typed ? res : combine(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (combined_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CIW-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_MODE: cur_mode = d[1:0];
      REG_ANTS: cur_ants = d[2:0];
      default: if (idx >= REG_CHAN0 && idx <= REG_CHAN_LAST) cur_chan[idx - REG_CHAN0] = d;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [1:0] md, logic [2:0] a, logic [31:0] ch[NANT]);
    drain();
    cfg_write(REG_MODE, 32'(md));
    cfg_write(REG_ANTS, 32'(a));
    for (int k = 0; k < NANT; k++) cfg_write(CIW'(REG_CHAN0 + k), ch[k]);
    // unused indices must be ignored
    if ($urandom_range(3) == 0) cfg_write(CIW'(REG_CHAN_LAST + 1 + $urandom_range(1)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_part();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dcmb_in_t rand_word();
    dcmb_in_t w;
    w = {rand_part(), rand_part(), rand_part(), rand_part(),
         rand_part(), rand_part(), rand_part(), rand_part()};
    return w;
  endfunction

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return {rand_part(), rand_part()};
      2: return {16'(int'($urandom_range(16)) - 8), 16'(int'($urandom_range(16)) - 8)};
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_row_t mk_row(dcmb_mode_t md, logic [2:0] a, logic [31:0] c0,
      logic [31:0] c1, logic [31:0] c2, logic [31:0] c3, dcmb_in_t w,
      bit typed = 1'b0, dcmb_out_t res = '0);
    vec_row_t r;
    r.mode = md;
    r.ants = a;
    r.ch = '{c0, c1, c2, c3};
    r.word = w;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // receiver stall, with one long hold-off so the pipe fills and stalls its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 200) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    dcmb_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (combined_q.size() == 0) begin
        $display("%0t unexpected word: got re=%h im=%h sat=%b bad=%b", $time,
                 out_word.out_re, out_word.out_im, out_word.saturated, out_word.bad_mode);
        errors++;
      end else begin
        e = combined_q.pop_front();
        if (out_word !== e) begin
          $display("%0t mismatch: expected re=%h im=%h sat=%b bad=%b, got re=%h im=%h sat=%b bad=%b",
                   $time, e.out_re, e.out_im, e.saturated, e.bad_mode,
                   out_word.out_re, out_word.out_im, out_word.saturated, out_word.bad_mode);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] ch[NANT];
    logic [1:0] md;
    int seg_left, phase_cnt;
    dcmb_in_t w;

    // directed vectors
    vec_rows.push_back(mk_row(MODE_MRC, 3'd1, 0, 0, 0, 0, '0, 1'b1, '{16'h0, 16'h0, 1'b0, 1'b0}));
    w = {16'h7fff, 16'h8000, 96'h0};
    vec_rows.push_back(mk_row(MODE_MRC, 3'd1, 0, 0, 0, 0, w, 1'b1, '{16'h0, 16'h0, 1'b0, 1'b0}));
    w = {16'h7fff, 16'h0000, 96'h0};
    vec_rows.push_back(mk_row(MODE_MRC, 3'd1, 32'h7fff0000, 0, 0, 0, w, 1'b1,
                              '{16'h7fff, 16'h0, 1'b1, 1'b0}));
    w = {16'h8000, 16'h8000, 96'h0};
    vec_rows.push_back(mk_row(MODE_MRC, 3'd1, 32'h80000000, 0, 0, 0, w, 1'b1,
                              '{16'h7fff, 16'h7fff, 1'b1, 1'b0}));
    w = {8{16'h8000}};
    vec_rows.push_back(mk_row(MODE_MRC, 3'd4, 0, 0, 0, 0, w, 1'b1, '{16'h0, 16'h0, 1'b0, 1'b0}));
    vec_rows.push_back(mk_row(MODE_MRC, 3'd4, 32'h80007fff, 32'h7fff8000, 32'h00010001,
                              32'h12345678, {8{16'h7fff}}));
    vec_rows.push_back(mk_row(MODE_MRC, 3'd0, 32'h40000000, 32'h7fff7fff, 0, 0, rand_word()));
    vec_rows.push_back(mk_row(MODE_MRC, 3'd7, 32'h00000001, 32'h80008000, 32'h7fff0000,
                              32'hffffffff, rand_word()));
    w = {16'h7fff, 16'h7fff, 96'h0};
    vec_rows.push_back(mk_row(MODE_EGC, 3'd1, 0, 0, 0, 0, w, 1'b1, '{16'h0, 16'h0, 1'b0, 1'b0}));
    vec_rows.push_back(mk_row(MODE_EGC, 3'd4, 32'h80008000, 32'h7fff7fff, 32'h80000000,
                              32'h00007fff, {8{16'h8000}}));
    vec_rows.push_back(mk_row(MODE_EGC, 3'd2, 32'h00010000, 32'h00000001, 0, 0, {8{16'h7fff}}));
    vec_rows.push_back(mk_row(MODE_EGC, 3'd6, 32'hffffffff, 0, 32'h7fff0001, 32'h0001ffff,
                              rand_word()));
    w = {16'h8000, 16'h7fff, 96'h0};
    vec_rows.push_back(mk_row(MODE_SEL, 3'd1, 0, 0, 0, 0, w, 1'b1,
                              '{16'h8000, 16'h7fff, 1'b0, 1'b0}));
    w = {16'h1234, 16'h8765, {6{16'h7fff}}};
    vec_rows.push_back(mk_row(MODE_SEL, 3'd4, 32'h40004000, 32'h40004000, 32'h40004000,
                              32'h40004000, w, 1'b1, '{16'h1234, 16'h8765, 1'b0, 1'b0}));
    vec_rows.push_back(mk_row(MODE_SEL, 3'd4, 32'h00010000, 32'h10000000, 32'h80008000,
                              32'h7fff7fff, rand_word()));
    vec_rows.push_back(mk_row(MODE_SEL, 3'd3, 32'h00010000, 32'h10000000, 32'h01000000,
                              32'h80008000, rand_word()));
    vec_rows.push_back(mk_row(MODE_BAD, 3'd4, 32'h7fff7fff, 32'h1, 32'h2, 32'h3, {8{16'h7fff}},
                              1'b1, '{16'h0, 16'h0, 1'b0, 1'b1}));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pct = 17;
    stall_pct = 63;
    foreach (vec_rows[i]) begin
      if (vec_rows[i].mode != cur_mode || vec_rows[i].ants != cur_ants ||
          vec_rows[i].ch != cur_chan)
        set_regs(vec_rows[i].mode, vec_rows[i].ants, vec_rows[i].ch);
      send_word(vec_rows[i].word, vec_rows[i].typed, vec_rows[i].res);
    end

    // random segments, each with its own register setting
    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 17 : (ph == 1) ? 63 : 0;
      stall_pct = (ph == 0) ? 63 : (ph == 1) ? 17 : 0;
      phase_cnt = 0;
      while (phase_cnt < RAND_PER_PHASE) begin
        md = ($urandom_range(9) == 0) ? MODE_BAD : 2'($urandom_range(2));
        for (int k = 0; k < NANT; k++) ch[k] = rand_chan();
        set_regs(md, 3'($urandom_range(7)), ch);
        seg_left = $urandom_range(20, 60);
        if (seg_left > RAND_PER_PHASE - phase_cnt) seg_left = RAND_PER_PHASE - phase_cnt;
        repeat (seg_left) begin
          send_word(rand_word());
          phase_cnt++;
        end
      end
    end

    drain();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
